>>> design/mdfpg_pkg.sv
// Shared types and constants for the multi-dot fade pattern generator.
package mdfpg_pkg;

  localparam int TIME_W     = 16;
  localparam int LEVEL_W    = 8;
  localparam int PHASE_W    = 18;
  localparam int DOT_IDX_W  = 3;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int RAMP_NUM_W = TIME_W + LEVEL_W;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;

  // Register reset values
  localparam logic [TIME_W-1:0]  RST_DOWN_TIME     = 16'd300;
  localparam logic [TIME_W-1:0]  RST_FADE_IN_TIME  = 16'd500;
  localparam logic [TIME_W-1:0]  RST_UP_TIME       = 16'd0;
  localparam logic [TIME_W-1:0]  RST_FADE_OUT_TIME = 16'd500;
  localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL     = 8'd0;
  localparam logic [TIME_W-1:0]  RST_DOT_LAG       = 16'd200;
  localparam logic [COUNT_W-1:0] RST_DOT_COUNT     = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOWN_TIME     = 3'd0,
    CFG_FADE_IN_TIME  = 3'd1,
    CFG_UP_TIME       = 3'd2,
    CFG_FADE_OUT_TIME = 3'd3,
    CFG_MIN_LEVEL     = 3'd4,
    CFG_DOT_LAG       = 3'd5,
    CFG_DOT_COUNT     = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PH_DIV,
    ST_DOT,
    ST_DOT_DIV,
    ST_SEG,
    ST_MUL,
    ST_NUM,
    ST_RAMP_DIV,
    ST_OUT
  } state_e;

endpackage

>>> design/mdfpg_div.sv
// Shared iterative restoring divider, one quotient bit per cycle.
module mdfpg_div #(
  parameter int DW = 24,
  parameter int VW = 18
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q, dvs_d;
  logic [VW:0]   trial;
  logic [VW:0]   diff;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // trial >= divisor when the subtraction does not borrow
      if (!diff[VW]) begin
        rem_d = diff[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> design/multi_dot_fade_pattern_generator.sv
// Top level of the multi-dot trapezoidal fade pattern generator.
//
// Input channel (in_valid_i / in_stall_o / delta_ms_i): one word is a tick
// carrying signed milliseconds since the previous tick. The phase advances
// by that amount and wraps into the period down + fade-in + up + fade-out.
// Output channel (out_valid_o / out_stall_i): one word per dot in use, in
// dot order, with dot_index_o, level_o (255 = full) and last_dot_o set on
// the final dot. A zero dot count updates the phase and sends nothing.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i; write
// only while no tick is in flight.
// Datapath: one shared restoring divider (DW = 24 bits at MAX_DOTS = 8, one
// bit per cycle) does every wrap and every ramp division. A tick runs the
// phase wrap, then per dot the wrap, the segment decode and, on a ramp,
// the multiply and the divide; a zero period skips every wrap.
// in_stall_o is high from acceptance until the sequencer is idle again.
// A stall on the output simply holds the current dot word and the sequencer.
// Reset: the config registers return to their defaults, phase to zero, idle.
module multi_dot_fade_pattern_generator #(
  parameter int MAX_DOTS = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // tick channel
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [mdfpg_pkg::TIME_W-1:0]     delta_ms_i,
  // dot level channel
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [mdfpg_pkg::DOT_IDX_W-1:0]         dot_index_o,
  output logic [mdfpg_pkg::LEVEL_W-1:0]           level_o,
  output logic                                    last_dot_o,
  // config write port
  input  logic                                    cfg_we_i,
  input  logic [mdfpg_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [mdfpg_pkg::CFG_DATA_W-1:0]        cfg_wdata_i
);

  import mdfpg_pkg::*;

  // Widths that follow from the dot bound: |phase - i * lag| needs MW bits
  localparam int LW = $clog2(MAX_DOTS);
  localparam int MW = 19 + LW;
  localparam int TW = MW + 1;
  localparam int DW = (MW > RAMP_NUM_W) ? MW : RAMP_NUM_W;
  localparam int IW = $clog2(MAX_DOTS + 1);

  // Config registers
  logic [TIME_W-1:0]  down_q, fin_q, up_q, fout_q;
  logic [LEVEL_W-1:0] min_q;
  logic [TIME_W-1:0]  lag_q;
  logic [COUNT_W-1:0] cnt_cfg_q;

  state_e state_q, state_d;

  logic [PHASE_W-1:0] phase_q;
  logic [PHASE_W-1:0] per_q, b1_q, b2_q, b3_q;
  logic [IW-1:0]      i_q, n_q;
  logic [DOT_IDX_W-1:0] dot_q;
  logic signed [TW-1:0] off_q;
  logic               neg_q;
  logic [PHASE_W-1:0] u_q;
  logic [TIME_W-1:0]  ofs_q, dvr_q;
  logic               ramp_in_q;
  logic [RAMP_NUM_W-1:0] prod_q;
  logic [LEVEL_W-1:0] level_q;

  // Combinational helpers
  logic [PHASE_W-1:0] b1_c, b2_c, b3_c, per_c;
  logic [IW-1:0]      n_c;
  logic signed [TW-1:0] phase_s, delta_s, lag_s, x_s;
  logic [MW-1:0]      x_mag, off_mag;
  logic [IW:0]        i_inc;
  logic [PHASE_W-1:0] wrap_c;
  logic [LEVEL_W-1:0] span;
  logic [RAMP_NUM_W-1:0] prod_c, num_c;
  logic               seg_ramp, seg_in;
  logic [LEVEL_W-1:0] seg_level;
  logic [PHASE_W-1:0] seg_ofs;
  logic               in_acc, out_acc;

  // Divider hookup
  logic               div_start, div_done;
  logic [DW-1:0]      div_dividend, div_quot;
  logic [PHASE_W-1:0] div_divisor, div_rem;

  mdfpg_div #(
    .DW(DW),
    .VW(PHASE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Segment bounds and period
  assign b1_c  = PHASE_W'(down_q);
  assign b2_c  = b1_c + PHASE_W'(fin_q);
  assign b3_c  = b2_c + PHASE_W'(up_q);
  assign per_c = b3_c + PHASE_W'(fout_q);

  // Dot count saturates at the bound
  always_comb begin
    if (int'(cnt_cfg_q) > MAX_DOTS) begin
      n_c = IW'(MAX_DOTS);
    end else begin
      n_c = IW'(cnt_cfg_q);
    end
  end

  assign phase_s = TW'(phase_q);
  assign delta_s = TW'(delta_ms_i);
  assign lag_s   = TW'($signed(lag_q));
  assign x_s     = phase_s + delta_s;
  assign x_mag   = x_s[TW-1] ? MW'(-x_s) : x_s[MW-1:0];
  assign off_mag = off_q[TW-1] ? MW'(-off_q) : off_q[MW-1:0];

  // Mathematical wrap: a negative operand with nonzero remainder folds up
  assign wrap_c = (neg_q && (div_rem != '0)) ? (per_q - div_rem) : div_rem;

  assign i_inc = {1'b0, i_q} + {{IW{1'b0}}, 1'b1};

  // Envelope segment decode
  always_comb begin
    seg_ramp  = 1'b0;
    seg_in    = 1'b0;
    seg_level = min_q;
    seg_ofs   = '0;
    priority if (u_q < b1_q) begin
      seg_level = min_q;
    end else if (u_q < b2_q) begin
      seg_ramp = 1'b1;
      seg_in   = 1'b1;
      seg_ofs  = u_q - b1_q;
    end else if (u_q < b3_q) begin
      seg_level = FULL_LEVEL;
    end else begin
      seg_ramp = 1'b1;
      seg_ofs  = u_q - b3_q;
    end
  end

  // Ramp numerator: fade-in m*F + u*span, fade-out 255*F - u*span
  assign span   = FULL_LEVEL - min_q;
  assign prod_c = RAMP_NUM_W'(ofs_q) * RAMP_NUM_W'(span);
  assign num_c  = ramp_in_q
                ? (RAMP_NUM_W'(min_q) * RAMP_NUM_W'(dvr_q)) + prod_q
                : ({dvr_q, {LEVEL_W{1'b0}}} - RAMP_NUM_W'(dvr_q)) - prod_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (per_c != '0) ? ST_PH_DIV : ST_DOT;
        end
      end
      ST_PH_DIV: begin
        if (div_done) state_d = ST_DOT;
      end
      ST_DOT: begin
        if (i_q == n_q) begin
          state_d = ST_IDLE;
        end else if (per_q == '0) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_DOT_DIV;
        end
      end
      ST_DOT_DIV: begin
        if (div_done) state_d = ST_SEG;
      end
      ST_SEG: begin
        state_d = seg_ramp ? ST_MUL : ST_OUT;
      end
      ST_MUL:  state_d = ST_NUM;
      ST_NUM:  state_d = ST_RAMP_DIV;
      ST_RAMP_DIV: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_DOT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs and divider operands
  always_comb begin
    in_stall_o   = 1'b1;
    out_valid_o  = 1'b0;
    div_start    = 1'b0;
    div_dividend = DW'(off_mag);
    div_divisor  = per_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        div_start    = in_valid_i && (per_c != '0);
        div_dividend = DW'(x_mag);
        div_divisor  = per_c;
      end
      ST_DOT: begin
        div_start = (i_q != n_q) && (per_q != '0);
      end
      ST_NUM: begin
        div_start    = 1'b1;
        div_dividend = DW'(num_c);
        div_divisor  = PHASE_W'(dvr_q);
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  // Control state, phase and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= '0;
      i_q       <= '0;
      down_q    <= RST_DOWN_TIME;
      fin_q     <= RST_FADE_IN_TIME;
      up_q      <= RST_UP_TIME;
      fout_q    <= RST_FADE_OUT_TIME;
      min_q     <= RST_MIN_LEVEL;
      lag_q     <= RST_DOT_LAG;
      cnt_cfg_q <= RST_DOT_COUNT;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        i_q <= '0;
      end else if (out_acc) begin
        i_q <= i_inc[IW-1:0];
      end
      if (state_q == ST_PH_DIV && div_done) begin
        phase_q <= wrap_c;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DOWN_TIME:     down_q    <= cfg_wdata_i;
          CFG_FADE_IN_TIME:  fin_q     <= cfg_wdata_i;
          CFG_UP_TIME:       up_q      <= cfg_wdata_i;
          CFG_FADE_OUT_TIME: fout_q    <= cfg_wdata_i;
          CFG_MIN_LEVEL:     min_q     <= cfg_wdata_i[LEVEL_W-1:0];
          CFG_DOT_LAG:       lag_q     <= cfg_wdata_i;
          CFG_DOT_COUNT:     cnt_cfg_q <= cfg_wdata_i[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      per_q <= per_c;
      b1_q  <= b1_c;
      b2_q  <= b2_c;
      b3_q  <= b3_c;
      n_q   <= n_c;
      dot_q <= '0;
      neg_q <= x_s[TW-1];
      off_q <= phase_s;
    end
    if (state_q == ST_PH_DIV && div_done) begin
      off_q <= TW'(wrap_c);
    end
    if (state_q == ST_DOT) begin
      neg_q   <= off_q[TW-1];
      level_q <= FULL_LEVEL;
    end
    if (state_q == ST_DOT_DIV && div_done) begin
      u_q <= wrap_c;
    end
    if (state_q == ST_SEG) begin
      level_q   <= seg_level;
      ofs_q     <= seg_ofs[TIME_W-1:0];
      ramp_in_q <= seg_in;
      dvr_q     <= seg_in ? fin_q : fout_q;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_c;
    end
    if (state_q == ST_RAMP_DIV && div_done) begin
      level_q <= div_quot[LEVEL_W-1:0];
    end
    if (out_acc) begin
      dot_q <= dot_q + 1'b1;
      off_q <= off_q - lag_s;
    end
  end

  assign dot_index_o = dot_q;
  assign level_o     = level_q;
  assign last_dot_o  = (i_inc == {1'b0, n_q});

endmodule

>>> tb/tb_multi_dot_fade_pattern_generator.sv
// Self-checking testbench for the multi-dot trapezoidal fade pattern generator.
`timescale 1ns / 1ps

// One expected dot word: index, brightness and end-of-row flag.
typedef struct packed {
  logic [mdfpg_pkg::DOT_IDX_W-1:0] dot;
  logic [mdfpg_pkg::LEVEL_W-1:0]   lvl;
  logic                            fin;
} dot_level_t;

// Keeps its own copy of the registers and the phase, predicts the dot
// levels of every accepted tick and checks the words that come out.
class fade_scoreboard #(int CAP = 8);
  logic [15:0]        hold_low_ms, rise_ms, hold_high_ms, fall_ms;
  logic [7:0]         floor_lvl;
  logic signed [15:0] lag_ms;
  logic [3:0]         dots_cfg;
  logic [17:0]        cur_phase;
  dot_level_t         level_q[$];
  int unsigned        mismatches;
  int unsigned        words_checked;

  function new();
    hold_low_ms   = mdfpg_pkg::RST_DOWN_TIME;
    rise_ms       = mdfpg_pkg::RST_FADE_IN_TIME;
    hold_high_ms  = mdfpg_pkg::RST_UP_TIME;
    fall_ms       = mdfpg_pkg::RST_FADE_OUT_TIME;
    floor_lvl     = mdfpg_pkg::RST_MIN_LEVEL;
    lag_ms        = mdfpg_pkg::RST_DOT_LAG;
    dots_cfg      = mdfpg_pkg::RST_DOT_COUNT;
    cur_phase     = '0;
    mismatches    = 0;
    words_checked = 0;
  endfunction

  function void set_reg(logic [mdfpg_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    case (idx)
      mdfpg_pkg::CFG_DOWN_TIME:     hold_low_ms  = val;
      mdfpg_pkg::CFG_FADE_IN_TIME:  rise_ms      = val;
      mdfpg_pkg::CFG_UP_TIME:       hold_high_ms = val;
      mdfpg_pkg::CFG_FADE_OUT_TIME: fall_ms      = val;
      mdfpg_pkg::CFG_MIN_LEVEL:     floor_lvl    = val[7:0];
      mdfpg_pkg::CFG_DOT_LAG:       lag_ms       = val;
      mdfpg_pkg::CFG_DOT_COUNT:     dots_cfg     = val[3:0];
      default: ;
    endcase
  endfunction

  // Mathematical modulo: result always in [0, per).
  function longint wrap_ms(longint t, longint per);
    longint r;
    r = t % per;
    if (r < 0) r += per;
    return r;
  endfunction

  // Trapezoid: floor, linear rise, full, linear fall; ramps truncate.
  function logic [7:0] shade(longint u);
    longint lo, ri, hi, fa, m, span, r;
    lo   = hold_low_ms;
    ri   = rise_ms;
    hi   = hold_high_ms;
    fa   = fall_ms;
    m    = floor_lvl;
    span = 255 - m;
    if (u < lo) begin
      r = m;
    end else if (u - lo < ri) begin
      r = (m * ri + (u - lo) * span) / ri;
    end else if (u - lo - ri < hi) begin
      r = 255;
    end else if (u - lo - ri - hi < fa) begin
      r = (255 * fa - (u - lo - ri - hi) * span) / fa;
    end else begin
      r = m;
    end
    return r[7:0];
  endfunction

  function void note_tick(logic signed [15:0] delta);
    longint     per, t;
    int         n;
    dot_level_t w;
    per = longint'(hold_low_ms) + longint'(rise_ms) + longint'(hold_high_ms)
        + longint'(fall_ms);
    // zero period freezes the phase
    if (per != 0)
      cur_phase = 18'(wrap_ms(longint'(cur_phase) + longint'(delta), per));
    n = (dots_cfg > CAP) ? CAP : dots_cfg;
    for (int i = 0; i < n; i++) begin
      w.dot = 3'(i);
      w.fin = (i + 1 == n);
      if (per == 0) begin
        w.lvl = mdfpg_pkg::FULL_LEVEL;
      end else begin
        t     = longint'(cur_phase) - longint'(i) * longint'(lag_ms);
        w.lvl = shade(wrap_ms(t, per));
      end
      level_q.push_back(w);
    end
  endfunction

  task flag(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task check_word(logic [2:0] dot, logic [7:0] lvl, logic fin);
    dot_level_t w;
    words_checked++;
    if (level_q.size() == 0) begin
      flag($sformatf("dot word %0d/%0d/%0d with nothing expected", dot, lvl, fin));
    end else begin
      w = level_q.pop_front();
      if (dot !== w.dot) flag($sformatf("dot_index %0d, expected %0d", dot, w.dot));
      if (lvl !== w.lvl)
        flag($sformatf("level %0d, expected %0d (dot %0d)", lvl, w.lvl, w.dot));
      if (fin !== w.fin)
        flag($sformatf("last_dot %0d, expected %0d (dot %0d)", fin, w.fin, w.dot));
    end
  endtask

  function int outstanding();
    return level_q.size();
  endfunction
endclass

module tb_multi_dot_fade_pattern_generator;
  import mdfpg_pkg::*;

  localparam int DOTS_MAX    = 8;
  localparam int TICK_TARGET = 180;        // directed and random parts together
  localparam int SETTLE_CYC  = 500;        // room for a tick that sends no words to finish
  localparam int CYCLE_LIMIT = 600_000;    // several times the slowest legal run
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic signed [15:0]    delta_ms_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [DOT_IDX_W-1:0]  dot_index_o;
  logic [LEVEL_W-1:0]    level_o;
  logic                  last_dot_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  fade_scoreboard #(DOTS_MAX) sb;

  int unsigned cycle_cnt    = 0;
  int unsigned ticks_sent   = 0;
  int unsigned settings_cnt = 0;
  int          stall_left   = 0;
  bit          in_calm      = 1'b0;
  bit          out_calm     = 1'b0;

  multi_dot_fade_pattern_generator #(.MAX_DOTS(DOTS_MAX)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .delta_ms_i  (delta_ms_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dot_index_o (dot_index_o),
    .level_o     (level_o),
    .last_dot_o  (last_dot_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d dot words still due", cycle_cnt,
               sb.outstanding());
      $display("tb_multi_dot_fade_pattern_generator: FAIL");
      $finish;
    end
  end

  // Idle/stall length per word; calm stretches run with no idling at all.
  function automatic int draw_wait(bit calm);
    if (calm) return 0;
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(1, 3);
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  // Output side: check every accepted dot word, then hold the next word
  // off for a random number of cycles once it shows up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_word(dot_index_o, level_o, last_dot_o);
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
        stall_left = draw_wait(out_calm);
      end else if (out_valid_o && stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Send one tick word. Valid stays high straight into the next word when
  // no gap is drawn, so it never drops and rises in the same step.
  task automatic send_tick(input logic signed [15:0] delta);
    int gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    delta_ms_i <= delta;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_tick(delta);
    ticks_sent++;
  endtask

  // Let the block drain: all dot words in, then room for a tick that
  // produces no words (dot count zero) to finish its phase update.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // Narrow registers get random junk above their width; it must be dropped.
  task automatic program_regs(input logic [15:0] lo, input logic [15:0] ri,
                              input logic [15:0] hi, input logic [15:0] fa,
                              input logic [7:0] minl, input logic [15:0] lag,
                              input logic [3:0] cnt);
    cfg_write(CFG_DOWN_TIME, lo);
    cfg_write(CFG_FADE_IN_TIME, ri);
    cfg_write(CFG_UP_TIME, hi);
    cfg_write(CFG_FADE_OUT_TIME, fa);
    cfg_write(CFG_MIN_LEVEL, {8'($urandom), minl});
    cfg_write(CFG_DOT_LAG, lag);
    cfg_write(CFG_DOT_COUNT, {12'($urandom), cnt});
    cfg_write(CFG_UNUSED_IDX, 16'($urandom));   // no register there
    cfg_we_i <= 1'b0;
    settings_cnt++;
  endtask

  function automatic logic [15:0] pick_span();
    case ($urandom_range(0, 9))
      0:          return 16'd0;
      1:          return 16'hFFFF;
      2, 3:       return 16'($urandom_range(1, 16));
      4, 5, 6, 7: return 16'($urandom_range(1, 1500));
      default:    return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0]         minl;
    logic [15:0]        lag;
    logic [3:0]         cnt;
    logic signed [15:0] delta;
    int                 burst;

    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // Reset values: period 1300, three dots 200 ms apart; walk the
    // segment edges and both delta extremes.
    send_tick(0);
    send_tick(300);
    send_tick(250);
    send_tick(450);
    send_tick(299);
    send_tick(-1);
    send_tick(32767);
    send_tick(-32768);

    // Widest period, most negative lag, count above the bound saturates.
    settle();
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 16'h8000, 4'd15);
    send_tick(32767);
    send_tick(32767);
    send_tick(-32768);

    // Period shrinks to 3 under a large phase: stale phase gets reduced;
    // up segment is empty.
    settle();
    program_regs(16'd1, 16'd1, 16'd0, 16'd1, 8'd0, 16'd1, 4'd8);
    send_tick(0);
    send_tick(1);
    send_tick(-1);

    // Zero period: phase frozen, every dot at full.
    settle();
    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 8'd77, 16'd7, 4'd5);
    send_tick(1234);
    send_tick(-5);

    // No dots: phase still moves, nothing comes out.
    settle();
    program_regs(16'd300, 16'd500, 16'd0, 16'd500, 8'd0, 16'd200, 4'd0);
    send_tick(10);
    send_tick(-20);

    // Rise-only envelope, largest positive lag.
    settle();
    program_regs(16'd0, 16'hFFFF, 16'd0, 16'd0, 8'd0, 16'h7FFF, 4'd8);
    send_tick(100);
    send_tick(-200);

    // Hold-then-fall envelope, single dot.
    settle();
    program_regs(16'd0, 16'd0, 16'hFFFF, 16'd7, 8'd200, -16'sd3, 4'd1);
    send_tick(32767);
    send_tick(3);

    // ---- random part: random settings, bursts of random ticks ----
    while (ticks_sent < TICK_TARGET) begin
      settle();
      in_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0:       minl = 8'd0;
        1:       minl = 8'd255;
        default: minl = 8'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       lag = 16'h8000;
        1:       lag = 16'h7FFF;
        2:       lag = 16'($urandom_range(0, 40) - 20);
        default: lag = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0:       cnt = 4'd0;
        1:       cnt = 4'($urandom_range(9, 15));
        default: cnt = 4'($urandom_range(1, 8));
      endcase
      program_regs(pick_span(), pick_span(), pick_span(), pick_span(), minl, lag, cnt);
      burst = $urandom_range(8, 24);
      repeat (burst) begin
        case ($urandom_range(0, 9))
          0:       delta = 0;
          1:       delta = 32767;
          2:       delta = -32768;
          3, 4:    delta = 16'($urandom_range(0, 100) - 50);
          5, 6:    delta = 16'($urandom_range(0, 3000));
          default: delta = 16'($urandom);
        endcase
        send_tick(delta);
      end
    end

    settle();
    $display("covered %0d ticks under %0d register settings, %0d dot levels compared",
             ticks_sent, settings_cnt + 1, sb.words_checked);
    $display("(reset values, zero period, no dots, saturated count, stale phase)");
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb_multi_dot_fade_pattern_generator: PASS");
    end else begin
      $display("tb_multi_dot_fade_pattern_generator: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
design/mdfpg_pkg.sv
design/mdfpg_div.sv
design/multi_dot_fade_pattern_generator.sv
tb/tb_multi_dot_fade_pattern_generator.sv
